[hdl/rmslm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rmslm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int RMS_W      = 15;
	localparam int SUM_W      = 40;
	localparam int ACC_W      = 32;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 16;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int SQ_W       = 32;                 // one square fits in 2^30
	localparam int DVD_W      = SUM_W - 3;          // sum / 8 before dividing by n
	localparam int DIV_STEPS  = DVD_W;
	localparam int RAD_W      = DVD_W + (DVD_W % 2);
	localparam int ROOT_W     = RAD_W / 2;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int SREM_W     = ROOT_W + 3;
	localparam int ITER_W     = $clog2(DIV_STEPS);
	localparam int TDATA_W    = 32;
	localparam int MAX_FRAMES_DEF = 512;

	localparam logic [RMS_W-1:0]   RMS_MAX  = 15'd16384;
	localparam logic [MUL_B_W-1:0] COEF_OLD = 16'd60948;
	localparam logic [MUL_B_W-1:0] COEF_NEW = 16'd4588;

	typedef enum logic [1:0] {
		MUL_LEFT,
		MUL_RIGHT,
		MUL_OLD,
		MUL_NEW
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_L,
		ST_SQ_R,
		ST_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_MUL_OLD,
		ST_MUL_NEW,
		ST_UPD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     add_sq;
		logic     count_inc;
		logic     div_init;
		logic     div_step;
		logic     sqrt_init;
		logic     sqrt_step;
		logic     wsum_load;
		logic     acc_update;
		logic     clear_block;
		logic     load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

`default_nettype wire

[hdl/block_rms_level_meter.sv]
// Block RMS level meter. Each request on the input stream is one stereo frame
// (two signed Q1.15 samples); tlast closes a block. Samples are halved and
// squared and summed over the block (only the first MAX_FRAMES frames of a
// block count; the sum saturates at 2^40-1). On the closing frame the block
// emits one result request: block_rms = floor(sqrt(sum / (8*n))) clamped to
// 16384, and smoothed_level, the integer part of 0.93*old + 0.07*new in
// Q0.16 weights (60948, 4588), rounded down. The block works on one frame at
// a time: a frame that does not close a block is accepted, its two squares
// go through one shared multiplier, and they are accumulated. A closing frame
// then runs the bit-serial divider (37 steps) and the two-bits-per-step
// square root (19 steps), followed by the smoothing multiplies.
// The result sits in an output register, so the next frame is accepted while
// a result still waits; a second result waits until the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module block_rms_level_meter #(
	parameter int MAX_FRAMES = rmslm_pkg::MAX_FRAMES_DEF   // 1..4096
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// frame input
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [rmslm_pkg::TDATA_W-1:0]   s_axis_tdata,  // [15:0] left_sample, [31:16] right_sample
	input  wire logic                            s_axis_tlast,  // last_frame
	// block result
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [rmslm_pkg::TDATA_W-1:0]        m_axis_tdata   // [14:0] block_rms, [29:15] smoothed_level, [31:30] zero
);

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	rmslm_pkg::cmd_t                    cmd;
	rmslm_pkg::status_t                 status;
	logic [rmslm_pkg::RMS_W-1:0]        out_rms, out_level;

	// sequencer: handshakes, iteration count, command strobes
	rmslm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// accumulator, shared multiplier, divider, root, smoothing state
	rmslm_dp #(
		.MAX_FRAMES (MAX_FRAMES),
		.CNT_W      (CNT_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_left   (s_axis_tdata[15:0]),
		.in_right  (s_axis_tdata[31:16]),
		.in_last   (s_axis_tlast),
		.status    (status),
		.out_rms   (out_rms),
		.out_level (out_level)
	);

	assign m_axis_tdata = {2'b00, out_level, out_rms};

endmodule

`default_nettype wire

[hdl/rmslm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmslm_dp #(
	parameter int MAX_FRAMES = rmslm_pkg::MAX_FRAMES_DEF,
	parameter int CNT_W      = $clog2(MAX_FRAMES + 1)
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire rmslm_pkg::cmd_t                  cmd,
	input  wire logic [rmslm_pkg::SAMPLE_W-1:0]   in_left,
	input  wire logic [rmslm_pkg::SAMPLE_W-1:0]   in_right,
	input  wire logic                             in_last,
	output rmslm_pkg::status_t                    status,
	output logic [rmslm_pkg::RMS_W-1:0]           out_rms,
	output logic [rmslm_pkg::RMS_W-1:0]           out_level
);

	localparam int SW = rmslm_pkg::SAMPLE_W;

	logic [SW-1:0]                     left_q, right_q;
	logic                              last_q, counted_q;
	logic [rmslm_pkg::SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [rmslm_pkg::ACC_W-1:0]       acc_q, wsum_q;
	logic [rmslm_pkg::MUL_P_W-1:0]     mul_q;
	logic [rmslm_pkg::DVD_W-1:0]       dvd_q;
	logic [CNT_W-1:0]                  drem_q;
	logic [rmslm_pkg::RAD_W-1:0]       rad_q;
	logic [rmslm_pkg::SREM_W-1:0]      srem_q;
	logic [rmslm_pkg::ROOT_W-1:0]      root_q;
	logic [rmslm_pkg::RMS_W-1:0]       rms_out_q, lvl_out_q;

	logic [SW-1:0]                     left_mag, right_mag;
	logic [rmslm_pkg::MUL_A_W-1:0]     mul_a;
	logic [rmslm_pkg::MUL_B_W-1:0]     mul_b;
	logic [rmslm_pkg::SUM_W:0]         sum_nxt;
	logic [CNT_W:0]                    dshift;
	logic                              dge;
	logic [rmslm_pkg::SREM_W-1:0]      sshift, strial;
	logic                              sge;
	logic [rmslm_pkg::RMS_W-1:0]       rms_clamp;
	logic [rmslm_pkg::ACC_W-1:0]       acc_nxt;

	// magnitude of a Q1.15 sample; -1.0 maps to 0x8000
	assign left_mag  = left_q[SW-1]  ? SW'(~left_q + 1'b1)  : left_q;
	assign right_mag = right_q[SW-1] ? SW'(~right_q + 1'b1) : right_q;

	// shared multiplier: squares, then the two smoothing weights
	always_comb begin
		unique case (cmd.mul_sel)
			rmslm_pkg::MUL_LEFT: begin
				mul_a = rmslm_pkg::MUL_A_W'(left_mag);
				mul_b = left_mag;
			end
			rmslm_pkg::MUL_RIGHT: begin
				mul_a = rmslm_pkg::MUL_A_W'(right_mag);
				mul_b = right_mag;
			end
			rmslm_pkg::MUL_OLD: begin
				mul_a = acc_q;
				mul_b = rmslm_pkg::COEF_OLD;
			end
			rmslm_pkg::MUL_NEW: begin
				mul_a = rmslm_pkg::MUL_A_W'(rms_clamp);
				mul_b = rmslm_pkg::COEF_NEW;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// saturating square accumulate
	assign sum_nxt = {1'b0, sum_q} + (rmslm_pkg::SUM_W + 1)'(mul_q[rmslm_pkg::SQ_W-1:0]);

	// restoring divide, one quotient bit per step
	assign dshift = {drem_q, dvd_q[rmslm_pkg::DVD_W-1]};
	assign dge    = dshift >= {1'b0, cnt_q};

	// floor square root, two radicand bits per step
	assign sshift = {srem_q[rmslm_pkg::SREM_W-3:0], rad_q[rmslm_pkg::RAD_W-1 -: 2]};
	assign strial = rmslm_pkg::SREM_W'({root_q, 2'b01});
	assign sge    = sshift >= strial;

	assign rms_clamp = (root_q > rmslm_pkg::ROOT_W'(rmslm_pkg::RMS_MAX)) ?
		rmslm_pkg::RMS_MAX : root_q[rmslm_pkg::RMS_W-1:0];

	// floor((acc*old + rms*new*2^16) / 2^16) = floor(acc*old / 2^16) + rms*new
	assign acc_nxt = wsum_q + mul_q[rmslm_pkg::ACC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			acc_q <= '0;
		end else begin
			if (cmd.add_sq && counted_q) begin
				sum_q <= sum_nxt[rmslm_pkg::SUM_W] ? '1 : sum_nxt[rmslm_pkg::SUM_W-1:0];
			end
			if (cmd.count_inc && counted_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.clear_block) begin
				sum_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.acc_update) begin
				acc_q <= acc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			left_q    <= in_left;
			right_q   <= in_right;
			last_q    <= in_last;
			counted_q <= cnt_q < CNT_W'(MAX_FRAMES);
		end
		if (cmd.mul_en) begin
			mul_q <= mul_a * mul_b;
		end
		if (cmd.div_init) begin
			dvd_q  <= sum_q[rmslm_pkg::SUM_W-1:3];
			drem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[rmslm_pkg::DVD_W-2:0], dge};
			drem_q <= dge ? CNT_W'(dshift - {1'b0, cnt_q}) : dshift[CNT_W-1:0];
		end
		if (cmd.sqrt_init) begin
			rad_q  <= rmslm_pkg::RAD_W'(dvd_q);
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[rmslm_pkg::RAD_W-3:0], 2'b00};
			srem_q <= sge ? (sshift - strial) : sshift;
			root_q <= {root_q[rmslm_pkg::ROOT_W-2:0], sge};
		end
		if (cmd.wsum_load) begin
			wsum_q <= mul_q[rmslm_pkg::MUL_P_W-1:16];
		end
		if (cmd.load_out) begin
			rms_out_q <= rms_clamp;
			lvl_out_q <= acc_q[16 +: rmslm_pkg::RMS_W];
		end
	end

	assign status.last = last_q;
	assign out_rms     = rms_out_q;
	assign out_level   = lvl_out_q;

endmodule

`default_nettype wire

[hdl/rmslm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmslm_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire rmslm_pkg::status_t status,
	output rmslm_pkg::cmd_t         cmd
);

	localparam logic [rmslm_pkg::ITER_W-1:0] DIV_LAST  =
		rmslm_pkg::ITER_W'(rmslm_pkg::DIV_STEPS - 1);
	localparam logic [rmslm_pkg::ITER_W-1:0] SQRT_LAST =
		rmslm_pkg::ITER_W'(rmslm_pkg::SQRT_STEPS - 1);

	rmslm_pkg::state_t             state_q, state_nxt;
	logic [rmslm_pkg::ITER_W-1:0]  iter_q;
	logic                          out_valid_q;
	logic                          out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rmslm_pkg::ST_IDLE:      if (in_valid) state_nxt = rmslm_pkg::ST_SQ_L;
			rmslm_pkg::ST_SQ_L:      state_nxt = rmslm_pkg::ST_SQ_R;
			rmslm_pkg::ST_SQ_R:      state_nxt = rmslm_pkg::ST_ACC;
			rmslm_pkg::ST_ACC:       state_nxt = status.last ? rmslm_pkg::ST_DIV_INIT
			                                                 : rmslm_pkg::ST_IDLE;
			rmslm_pkg::ST_DIV_INIT:  state_nxt = rmslm_pkg::ST_DIV;
			rmslm_pkg::ST_DIV:       if (iter_q == DIV_LAST) state_nxt = rmslm_pkg::ST_SQRT_INIT;
			rmslm_pkg::ST_SQRT_INIT: state_nxt = rmslm_pkg::ST_SQRT;
			rmslm_pkg::ST_SQRT:      if (iter_q == SQRT_LAST) state_nxt = rmslm_pkg::ST_MUL_OLD;
			rmslm_pkg::ST_MUL_OLD:   state_nxt = rmslm_pkg::ST_MUL_NEW;
			rmslm_pkg::ST_MUL_NEW:   state_nxt = rmslm_pkg::ST_UPD;
			rmslm_pkg::ST_UPD:       state_nxt = rmslm_pkg::ST_EMIT;
			rmslm_pkg::ST_EMIT:      if (out_free) state_nxt = rmslm_pkg::ST_IDLE;
			default:                 state_nxt = rmslm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = rmslm_pkg::MUL_LEFT;
		in_ready    = 1'b0;
		unique case (state_q)
			rmslm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			rmslm_pkg::ST_SQ_L: begin
				cmd.mul_en = 1'b1;
			end
			rmslm_pkg::ST_SQ_R: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rmslm_pkg::MUL_RIGHT;
				cmd.add_sq  = 1'b1;
			end
			rmslm_pkg::ST_ACC: begin
				cmd.add_sq    = 1'b1;
				cmd.count_inc = 1'b1;
			end
			rmslm_pkg::ST_DIV_INIT:  cmd.div_init  = 1'b1;
			rmslm_pkg::ST_DIV:       cmd.div_step  = 1'b1;
			rmslm_pkg::ST_SQRT_INIT: cmd.sqrt_init = 1'b1;
			rmslm_pkg::ST_SQRT:      cmd.sqrt_step = 1'b1;
			rmslm_pkg::ST_MUL_OLD: begin
				cmd.mul_en      = 1'b1;
				cmd.mul_sel     = rmslm_pkg::MUL_OLD;
				cmd.clear_block = 1'b1;
			end
			rmslm_pkg::ST_MUL_NEW: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = rmslm_pkg::MUL_NEW;
				cmd.wsum_load = 1'b1;
			end
			rmslm_pkg::ST_UPD:  cmd.acc_update = 1'b1;
			rmslm_pkg::ST_EMIT: cmd.load_out   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmslm_pkg::ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == rmslm_pkg::ST_DIV) || (state_q == rmslm_pkg::ST_SQRT)) begin
				iter_q <= (state_nxt == state_q) ? iter_q + 1'b1 : '0;
			end else begin
				iter_q <= '0;
			end
			if ((state_q == rmslm_pkg::ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[hdl/rmslm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module rmslm_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic                           s_axis_tlast,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [rmslm_pkg::TDATA_W-1:0]  m_axis_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one frame at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// a non-closing frame frees the input once it is squared and accumulated
	a_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> ##3 s_axis_tready)
		else $error("non-closing frame took too long");

	// a new result only comes out of the busy result phase
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared while input was open");

	// both levels stay within full scale of the halved samples
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[14:0] <= 15'd16384) &&
		                  (m_axis_tdata[29:15] <= 15'd16384))
		else $error("level out of range");

endmodule

bind block_rms_level_meter rmslm_checker u_rmslm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/block_rms_level_meter_tb.sv]
`timescale 1ns / 1ps

module block_rms_level_meter_tb;

	// cycles without any accepted request before the run is declared hung
	localparam int HANG_LIMIT = 20000;
	localparam bit [63:0] SUM_LIMIT = (64'd1 << rmslm_pkg::SUM_W) - 1;

	typedef struct {
		logic [rmslm_pkg::RMS_W-1:0] rms;
		logic [rmslm_pkg::RMS_W-1:0] level;
	} level_result_t;

	typedef enum {
		KIND_RANDOM,
		KIND_QUIET,
		KIND_FULL,
		KIND_ZERO,
		KIND_FULL_NEG
	} sample_kind_t;

	// Tracks the meter's state from accepted frames and holds the results
	// that closing frames must produce, oldest first.
	class level_scoreboard;
		bit [rmslm_pkg::SUM_W-1:0]  square_total;
		int unsigned                frame_count;
		bit [rmslm_pkg::ACC_W-1:0]  level_acc;
		level_result_t              pending[$];
		int unsigned                mismatches;

		function new();
			square_total = '0;
			frame_count  = 0;
			level_acc    = '0;
			mismatches   = 0;
		endfunction

		function bit [63:0] floor_root(bit [63:0] v);
			bit [63:0] r;
			bit [63:0] t;
			r = 0;
			// v < 2^37, so the root fits in 19 bits
			for (int b = 20; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= v)
					r = t;
			end
			return r;
		endfunction

		function void note_frame(logic signed [rmslm_pkg::SAMPLE_W-1:0] left,
					 logic signed [rmslm_pkg::SAMPLE_W-1:0] right, logic last);
			longint        sq;
			bit [63:0]     total;
			bit [63:0]     mean;
			bit [63:0]     root;
			bit [63:0]     mix;
			level_result_t res;
			// frames past a full block are dropped, but may still close it
			if (frame_count < rmslm_pkg::MAX_FRAMES_DEF) begin
				sq = longint'(left) * longint'(left) + longint'(right) * longint'(right);
				total = 64'(square_total) + 64'(sq);
				square_total = (total > SUM_LIMIT) ? SUM_LIMIT[rmslm_pkg::SUM_W-1:0]
				                                   : total[rmslm_pkg::SUM_W-1:0];
				frame_count++;
			end
			if (!last)
				return;
			// (x/2)^2 = x^2/4, hence the divisor 8*n over both channels
			mean = 64'(square_total) / (64'(frame_count) * 64'd8);
			root = floor_root(mean);
			if (root > 64'(rmslm_pkg::RMS_MAX))
				root = 64'(rmslm_pkg::RMS_MAX);
			mix = (64'(level_acc) * 64'(rmslm_pkg::COEF_OLD) +
			       root * 64'(rmslm_pkg::COEF_NEW) * 64'd65536) >> 16;
			level_acc = mix[rmslm_pkg::ACC_W-1:0];
			res.rms   = root[rmslm_pkg::RMS_W-1:0];
			res.level = level_acc[16 +: rmslm_pkg::RMS_W];
			pending = {pending, res};
			square_total = '0;
			frame_count  = 0;
		endfunction

		task report_mismatch(string what);
			$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		endtask

		// tdata: [14:0] block_rms, [29:15] smoothed_level, [31:30] zero
		task check_result(logic [rmslm_pkg::TDATA_W-1:0] data);
			level_result_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result 0x%08h with nothing expected", data));
				return;
			end
			want = pending.pop_front();
			if (data[rmslm_pkg::RMS_W-1:0] !== want.rms)
				report_mismatch($sformatf("block_rms %0d, expected %0d",
					data[rmslm_pkg::RMS_W-1:0], want.rms));
			if (data[rmslm_pkg::RMS_W +: rmslm_pkg::RMS_W] !== want.level)
				report_mismatch($sformatf("smoothed_level %0d, expected %0d",
					data[rmslm_pkg::RMS_W +: rmslm_pkg::RMS_W], want.level));
			if (data[rmslm_pkg::TDATA_W-1:2*rmslm_pkg::RMS_W] !== '0)
				report_mismatch($sformatf("pad bits 0x%0h, expected zero",
					data[rmslm_pkg::TDATA_W-1:2*rmslm_pkg::RMS_W]));
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [rmslm_pkg::TDATA_W-1:0] s_axis_tdata = '0;  // [15:0] left_sample, [31:16] right_sample
	logic                          s_axis_tlast = 1'b0; // last_frame
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [rmslm_pkg::TDATA_W-1:0] m_axis_tdata;      // [14:0] block_rms, [29:15] smoothed_level

	// idle odds in percent, changed per phase
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	// when nonzero the receiver refuses results for that many cycles
	int rx_hold_left = 0;
	int quiet_cycles = 0;

	level_scoreboard tally = new();

	block_rms_level_meter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Monitor: sampled at the edge, before the design's own updates land.
	// A closing frame noted here cannot produce its result on the same edge,
	// so noting before checking keeps the queue order right.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				tally.note_frame(s_axis_tdata[rmslm_pkg::SAMPLE_W-1:0],
					s_axis_tdata[2*rmslm_pkg::SAMPLE_W-1:rmslm_pkg::SAMPLE_W],
					s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				tally.check_result(m_axis_tdata);
		end
	end

	// Result side: random stalls, or a counted hold-off when one is armed.
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Hang detector: any accepted request on either side restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("%0t ns: timeout, no request accepted for %0d cycles",
					$time, HANG_LIMIT);
				$display("block_rms_level_meter_tb failed");
				$finish;
			end
		end
	end

	// One frame request. Gaps lower tvalid first; back-to-back frames keep it
	// high so tvalid never gets two updates in one step.
	task send_frame(logic [rmslm_pkg::SAMPLE_W-1:0] left,
			logic [rmslm_pkg::SAMPLE_W-1:0] right, logic last);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {right, left};
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	function logic [rmslm_pkg::SAMPLE_W-1:0] make_sample(sample_kind_t kind);
		case (kind)
			KIND_QUIET:    return rmslm_pkg::SAMPLE_W'($urandom_range(1023)) - 16'd512;
			KIND_FULL:     return $urandom_range(1) ? 16'h7fff : 16'h8000;
			KIND_ZERO:     return '0;
			KIND_FULL_NEG: return 16'h8000;
			default:       return rmslm_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task send_block(int len, sample_kind_t kind);
		for (int i = 0; i < len; i++)
			send_frame(make_sample(kind), make_sample(kind), i == len - 1);
	endtask

	task run_random(int count);
		int           sent;
		int           len;
		int           pick;
		sample_kind_t kind;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 85)
				len = $urandom_range(10, 1);
			else
				len = $urandom_range(60, 11);
			pick = $urandom_range(99);
			if (pick < 50)
				kind = KIND_RANDOM;
			else if (pick < 75)
				kind = KIND_QUIET;
			else if (pick < 90)
				kind = KIND_FULL;
			else
				kind = KIND_ZERO;
			send_block(len, kind);
			sent += len;
		end
	endtask

	// one edge first so the last accepted frame is already noted
	task wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (tally.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes as one-frame blocks, short blocks, bit patterns
		send_frame(16'h0000, 16'h0000, 1'b1);
		send_frame(16'h7fff, 16'h7fff, 1'b1);
		send_frame(16'h8000, 16'h8000, 1'b1);   // largest RMS, 16384
		send_frame(16'h7fff, 16'h8000, 1'b1);
		send_frame(16'hffff, 16'h0001, 1'b1);
		send_frame(16'h5555, 16'haaaa, 1'b1);
		send_frame(16'haaaa, 16'h5555, 1'b1);
		send_frame(16'h4000, 16'hc000, 1'b0);
		send_frame(16'h0000, 16'h0000, 1'b1);
		send_frame(16'h0001, 16'hffff, 1'b0);
		send_frame(16'h0002, 16'hfffe, 1'b0);
		send_frame(16'h0003, 16'hfffd, 1'b1);
		// walk the smoothed level up with full-scale, then back down
		for (int i = 0; i < 6; i++)
			send_frame(16'h8000, 16'h8000, 1'b1);
		for (int i = 0; i < 4; i++)
			send_frame(16'h0000, 16'h0000, 1'b1);
		wait_drained();

		// random phases: clean, sender gaps, receiver stalls, both
		tx_idle_pct = 0;  rx_stall_pct = 0;
		run_random(80);
		// full-scale block past MAX_FRAMES: sum saturates, tail is dropped
		send_block(rmslm_pkg::MAX_FRAMES_DEF + 8, KIND_FULL_NEG);
		tx_idle_pct = 63; rx_stall_pct = 0;
		run_random(80);
		tx_idle_pct = 0;  rx_stall_pct = 63;
		run_random(80);
		// closing frame lands one past a full block
		send_block(rmslm_pkg::MAX_FRAMES_DEF + 1, KIND_RANDOM);
		tx_idle_pct = 20; rx_stall_pct = 20;
		run_random(80);

		// receiver holds off while frames keep coming: output register fills,
		// a second result backs up and input requests stall
		tx_idle_pct = 0;  rx_stall_pct = 0;
		rx_hold_left = 1500;
		for (int k = 0; k < 16; k++)
			send_block(3, KIND_RANDOM);

		// sender pauses until every result is out, then a last mixed stretch
		wait_drained();
		tx_idle_pct = 20; rx_stall_pct = 20;
		run_random(80);

		wait_drained();
		repeat (200) @(posedge clk);
		if (tally.mismatches == 0 && tally.pending.size() == 0)
			$display("block_rms_level_meter_tb passed");
		else
			$display("block_rms_level_meter_tb failed");
		$finish;
	end

endmodule
